// ----- src/sjp_pkg.sv -----
// ----------------------------------------------------------------------------
// sjp_pkg
// Types, constants and table builder for the S-curve jerk profile generator.
// ----------------------------------------------------------------------------
package sjp_pkg;

    localparam int ADDR_W     = 5;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int START_W    = 35;
    localparam int PHASE_W    = 4;
    localparam int NUM_PHASES = 15;
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(NUM_PHASES - 1);

    localparam logic [63:0] HALF_SQRT3_Q32 = 64'd3719550787;
    localparam logic [63:0] LN2_Q32        = 64'd2977044472;

    localparam logic signed [PROD_W-1:0] SAT_MAX = {{(PROD_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_MIN = {{(PROD_W-31){1'b1}}, {31{1'b0}}};

    typedef enum logic [2:0] {
        REG_PHASE_S   = 3'd0,
        REG_PHASE_J   = 3'd1,
        REG_PHASE_A   = 3'd2,
        REG_PHASE_V   = 3'd3,
        REG_RECIP_S   = 3'd4,
        REG_JERK_PEAK = 3'd5,
        REG_STEP      = 3'd6,
        REG_START_POS = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_RISE,
        KIND_HOLD,
        KIND_FALL
    } t_kind;

    typedef enum logic [1:0] {
        DUR_S,
        DUR_J,
        DUR_A,
        DUR_V
    } t_dur;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_TAU_MUL,
        ST_TAU_IDX,
        ST_JRK_MUL,
        ST_JRK_SAT,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_VEL_MUL,
        ST_VEL_ADD,
        ST_POS_MUL,
        ST_POS_ADD
    } t_state;

    typedef struct packed {
        logic        [30:0] phase_s_len;
        logic        [30:0] phase_j_len;
        logic        [30:0] phase_a_len;
        logic        [30:0] phase_v_len;
        logic        [30:0] recip_phase_s;
        logic signed [31:0] jerk_peak;
        logic        [30:0] sample_step;
        logic signed [31:0] start_position;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] jerk;
        logic signed [31:0] accel;
        logic signed [31:0] velocity;
        logic signed [31:0] position;
        logic               done;
    } t_result;

    localparam t_cfg CFG_RESET = '{
        phase_s_len:    31'd0,
        phase_j_len:    31'd0,
        phase_a_len:    31'd0,
        phase_v_len:    31'd0,
        recip_phase_s:  31'd0,
        jerk_peak:      32'sd0,
        sample_step:    31'd655,
        start_position: 32'sd0
    };

    localparam t_dur PHASE_DUR [NUM_PHASES] = '{
        DUR_S, DUR_J, DUR_S, DUR_A, DUR_S, DUR_J, DUR_S, DUR_V,
        DUR_S, DUR_J, DUR_S, DUR_A, DUR_S, DUR_J, DUR_S
    };

    localparam t_kind PHASE_KIND [NUM_PHASES] = '{
        KIND_RISE, KIND_HOLD, KIND_FALL, KIND_ZERO,
        KIND_RISE, KIND_HOLD, KIND_FALL, KIND_ZERO,
        KIND_RISE, KIND_HOLD, KIND_FALL, KIND_ZERO,
        KIND_RISE, KIND_HOLD, KIND_FALL
    };

    localparam logic PHASE_NEG [NUM_PHASES] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0,
        1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0
    };

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [PROD_W-1:0] widen(input logic signed [31:0] v);
        return PROD_W'(v);
    endfunction

    // Shift-subtract long division, evaluated while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [31:0] smooth_entry(input int idx, input int frac, input int depth);
        logic [63:0]        d2;
        logic [63:0]        p;
        logic [63:0]        q;
        logic [63:0]        tmp;
        logic [63:0]        z;
        logic [63:0]        k;
        logic [63:0]        r;
        logic [63:0]        term;
        logic [63:0]        e;
        logic [63:0]        den;
        logic [63:0]        one_v;
        logic [63:0]        val;
        logic signed [63:0] sum;
        logic               flip;
        d2 = 64'(2 * depth);
        p  = 64'(2 * idx + 1);
        if (p >= d2) begin
            p = d2 - 64'd1;
        end
        q    = d2 - p;
        flip = (p < q);
        if (flip) begin
            tmp = p;
            p   = q;
            q   = tmp;
        end
        z = udiv64(d2 * (p - q) * HALF_SQRT3_Q32, p * q);
        k = udiv64(z, LN2_Q32);
        if (k >= 64'd40) begin
            e = '0;
        end else begin
            r    = z - k * LN2_Q32;
            term = 64'd1 << 32;
            sum  = signed'(term);
            for (int n = 1; n <= 13; n++) begin
                term = udiv64((term * r) >> 32, 64'(n));
                if (n[0]) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            e = unsigned'(sum) >> k;
        end
        one_v = 64'd1 << frac;
        den   = (64'd1 << 32) + e;
        val   = udiv64((one_v << 32) + (den >> 1), den);
        if (val > one_v) begin
            val = one_v;
        end
        return flip ? 32'(one_v - val) : 32'(val);
    endfunction

endpackage

// ----- src/sjp_smooth_rom.sv -----
// ----------------------------------------------------------------------------
// sjp_smooth_rom
// Logistic step table with registered read data.
// ----------------------------------------------------------------------------
module sjp_smooth_rom
    import sjp_pkg::*;
#(
    parameter int FRAC_BITS          = 16,
    parameter int SMOOTH_TABLE_DEPTH = 256,
    localparam int IDX_W             = $clog2(SMOOTH_TABLE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic [IDX_W-1:0]     i_addr,
    output logic [FRAC_BITS:0]   o_data
);

    logic [FRAC_BITS:0] w_rom [SMOOTH_TABLE_DEPTH];
    logic [FRAC_BITS:0] r_data;

    for (genvar g = 0; g < SMOOTH_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [31:0] ENTRY = smooth_entry(g, FRAC_BITS, SMOOTH_TABLE_DEPTH);
        assign w_rom[g] = ENTRY[FRAC_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

// ----- src/sjp_mul.sv -----
// ----------------------------------------------------------------------------
// sjp_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module sjp_mul
    import sjp_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- src/sjp_core.sv -----
// ----------------------------------------------------------------------------
// sjp_core
// Phase walk, jerk shaping and trapezoid integration on one shared multiplier.
// ----------------------------------------------------------------------------
module sjp_core
    import sjp_pkg::*;
#(
    parameter int FRAC_BITS          = 16,
    parameter int SMOOTH_TABLE_DEPTH = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_start,
    input  logic    i_restart,
    input  logic    i_hold,
    output logic    o_busy,
    output logic    o_commit,
    output t_result o_result
);

    localparam int IDX_W = $clog2(SMOOTH_TABLE_DEPTH);
    localparam int IP_W  = FRAC_BITS + IDX_W + 2;
    localparam int IQ_W  = IDX_W + 2;
    localparam int TR_W  = PROD_W - FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [IQ_W-1:0]    IDX_MAX = IQ_W'(SMOOTH_TABLE_DEPTH - 1);

    t_state r_state;
    t_state n_state;

    logic        [31:0]        r_time;
    logic signed [31:0]        r_jerk;
    logic signed [31:0]        r_acc;
    logic signed [31:0]        r_vel;
    logic signed [31:0]        r_pos;
    logic        [PHASE_W-1:0] r_phase;
    logic        [START_W-1:0] r_start;
    logic        [30:0]        r_offset;
    t_kind                     r_kind;
    logic                      r_neg;
    logic                      r_done;
    logic signed [31:0]        r_jrk_nx;
    logic signed [31:0]        r_acc_nx;
    logic signed [31:0]        r_vel_nx;

    logic        [30:0]        w_len;
    logic        [START_W-1:0] w_end;
    logic        [START_W-1:0] w_diff;
    logic                      w_hit;
    logic signed [MUL_W-1:0]   w_mul_a;
    logic signed [MUL_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic        [TR_W-1:0]    w_tau_raw;
    logic        [FRAC_BITS:0] w_tau;
    logic        [IP_W-1:0]    w_idx_prod;
    logic        [IQ_W-1:0]    w_idx_q;
    logic        [IDX_W-1:0]   w_idx;
    logic        [FRAC_BITS:0] w_rom_q;
    logic        [FRAC_BITS:0] w_s;
    logic signed [PROD_W-1:0]  w_jrk_sh;
    logic signed [PROD_W-1:0]  w_jrk_val;
    logic signed [PROD_W-1:0]  w_trap;
    logic signed [31:0]        w_base;
    logic signed [31:0]        w_int;
    logic        [32:0]        w_time_sum;
    logic        [31:0]        w_time_nx;

    sjp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    sjp_smooth_rom #(
        .FRAC_BITS          (FRAC_BITS),
        .SMOOTH_TABLE_DEPTH (SMOOTH_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_idx),
        .o_data (w_rom_q)
    );

    always_comb begin
        case (PHASE_DUR[r_phase])
            DUR_S:   w_len = i_cfg.phase_s_len;
            DUR_J:   w_len = i_cfg.phase_j_len;
            DUR_A:   w_len = i_cfg.phase_a_len;
            default: w_len = i_cfg.phase_v_len;
        endcase
    end

    assign w_end  = r_start + START_W'(w_len);
    assign w_diff = START_W'(r_time) - r_start;
    assign w_hit  = (START_W'(r_time) < w_end);

    assign w_tau_raw  = w_prod[PROD_W-1:FRAC_BITS];
    assign w_tau      = (w_tau_raw > TR_W'(ONE)) ? ONE : w_tau_raw[FRAC_BITS:0];
    assign w_idx_prod = IP_W'(w_tau) * IP_W'(SMOOTH_TABLE_DEPTH);
    assign w_idx_q    = w_idx_prod[IP_W-1:FRAC_BITS];
    assign w_idx      = (w_idx_q > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : w_idx_q[IDX_W-1:0];

    always_comb begin
        case (r_kind)
            KIND_RISE: w_s = w_rom_q;
            KIND_HOLD: w_s = ONE;
            KIND_FALL: w_s = ONE - w_rom_q;
            default:   w_s = '0;
        endcase
    end

    assign w_jrk_sh  = w_prod >>> FRAC_BITS;
    assign w_jrk_val = r_neg ? -w_jrk_sh : w_jrk_sh;
    assign w_trap    = w_prod >>> (FRAC_BITS + 1);

    always_comb begin
        case (r_state)
            ST_VEL_ADD: w_base = r_vel;
            ST_POS_ADD: w_base = r_pos;
            default:    w_base = r_acc;
        endcase
    end

    assign w_int      = sat32(w_trap + widen(w_base));
    assign w_time_sum = {1'b0, r_time} + 33'(i_cfg.sample_step);
    assign w_time_nx  = w_time_sum[32] ? '1 : w_time_sum[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (w_hit) begin
                    if (PHASE_KIND[r_phase] inside {KIND_RISE, KIND_FALL}) begin
                        n_state = ST_TAU_MUL;
                    end else begin
                        n_state = ST_JRK_MUL;
                    end
                end else if (r_phase == LAST_PHASE) begin
                    n_state = ST_JRK_MUL;
                end
            end
            ST_TAU_MUL: begin
                w_mul_a = signed'(MUL_W'(r_offset));
                w_mul_b = signed'(MUL_W'(i_cfg.recip_phase_s));
                n_state = ST_TAU_IDX;
            end
            ST_TAU_IDX: n_state = ST_JRK_MUL;
            ST_JRK_MUL: begin
                w_mul_a = MUL_W'(i_cfg.jerk_peak);
                w_mul_b = signed'(MUL_W'(w_s));
                n_state = ST_JRK_SAT;
            end
            ST_JRK_SAT: n_state = ST_ACC_MUL;
            ST_ACC_MUL: begin
                w_mul_a = MUL_W'(r_jerk) + MUL_W'(r_jrk_nx);
                w_mul_b = signed'(MUL_W'(i_cfg.sample_step));
                n_state = ST_ACC_ADD;
            end
            ST_ACC_ADD: n_state = ST_VEL_MUL;
            ST_VEL_MUL: begin
                w_mul_a = MUL_W'(r_acc) + MUL_W'(r_acc_nx);
                w_mul_b = signed'(MUL_W'(i_cfg.sample_step));
                n_state = ST_VEL_ADD;
            end
            ST_VEL_ADD: n_state = ST_POS_MUL;
            ST_POS_MUL: begin
                w_mul_a = MUL_W'(r_vel) + MUL_W'(r_vel_nx);
                w_mul_b = signed'(MUL_W'(i_cfg.sample_step));
                n_state = ST_POS_ADD;
            end
            ST_POS_ADD: begin
                w_mul_a = MUL_W'(r_vel) + MUL_W'(r_vel_nx);
                w_mul_b = signed'(MUL_W'(i_cfg.sample_step));
                if (!i_hold) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_jerk <= '0;
            r_acc  <= '0;
            r_vel  <= '0;
            r_pos  <= '0;
        end else if (r_state == ST_IDLE && i_start && i_restart) begin
            r_time <= '0;
            r_pos  <= i_cfg.start_position;
        end else if (o_commit) begin
            r_time <= w_time_nx;
            r_jerk <= r_jrk_nx;
            r_acc  <= r_acc_nx;
            r_vel  <= r_vel_nx;
            r_pos  <= w_int;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_phase <= '0;
                r_start <= '0;
            end
            ST_SRCH: begin
                if (w_hit) begin
                    r_kind   <= PHASE_KIND[r_phase];
                    r_neg    <= PHASE_NEG[r_phase];
                    r_offset <= w_diff[30:0];
                    r_done   <= 1'b0;
                end else begin
                    r_start <= w_end;
                    r_phase <= r_phase + 1'b1;
                    r_kind  <= KIND_ZERO;
                    r_neg   <= 1'b0;
                    r_done  <= 1'b1;
                end
            end
            ST_JRK_SAT: r_jrk_nx <= sat32(w_jrk_val);
            ST_ACC_ADD: r_acc_nx <= w_int;
            ST_VEL_ADD: r_vel_nx <= w_int;
            default: ;
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_commit = (r_state == ST_POS_ADD) && !i_hold;

    assign o_result = '{
        jerk:     r_jrk_nx,
        accel:    r_acc_nx,
        velocity: r_vel_nx,
        position: w_int,
        done:     r_done
    };

endmodule

// ----- src/scurve_jerk_profile_generator.sv -----
// ----------------------------------------------------------------------------
// scurve_jerk_profile_generator
// Flow: an input beat starts a tick that walks the phases one per cycle, 1 to 15 of them,
// forms the tau product and reads the table when the tick falls in a smooth phase, then
// shapes jerk and integrates accel, velocity and position, all on one shared multiplier. A
// new beat waits for the tick's end; input ready is low while a tick is in flight or stalled.
// Reset: synchronous active low; registers to defaults, tick state and output valid cleared.
// ----------------------------------------------------------------------------
module scurve_jerk_profile_generator
    import sjp_pkg::*;
#(
    parameter int FRAC_BITS          = 16,
    parameter int SMOOTH_TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_restart,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_jerk_out,
    output logic signed [31:0] o_accel_out,
    output logic signed [31:0] o_velocity_out,
    output logic signed [31:0] o_position_out,
    output logic               o_profile_done
);

    t_cfg     r_cfg;
    t_result  r_out;
    logic     r_out_valid;
    t_reg_idx w_reg;
    logic     w_cfg_we;
    logic     w_busy;
    logic     w_start;
    logic     w_hold;
    logic     w_commit;
    t_result  w_result;

    assign w_reg    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_cfg_we = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_cfg_we) begin
            case (w_reg)
                REG_PHASE_S:   r_cfg.phase_s_len    <= pwdata[30:0];
                REG_PHASE_J:   r_cfg.phase_j_len    <= pwdata[30:0];
                REG_PHASE_A:   r_cfg.phase_a_len    <= pwdata[30:0];
                REG_PHASE_V:   r_cfg.phase_v_len    <= pwdata[30:0];
                REG_RECIP_S:   r_cfg.recip_phase_s  <= pwdata[30:0];
                REG_JERK_PEAK: r_cfg.jerk_peak      <= pwdata;
                REG_STEP:      r_cfg.sample_step    <= pwdata[30:0];
                REG_START_POS: r_cfg.start_position <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_PHASE_S:   prdata = 32'(r_cfg.phase_s_len);
            REG_PHASE_J:   prdata = 32'(r_cfg.phase_j_len);
            REG_PHASE_A:   prdata = 32'(r_cfg.phase_a_len);
            REG_PHASE_V:   prdata = 32'(r_cfg.phase_v_len);
            REG_RECIP_S:   prdata = 32'(r_cfg.recip_phase_s);
            REG_JERK_PEAK: prdata = r_cfg.jerk_peak;
            REG_STEP:      prdata = 32'(r_cfg.sample_step);
            REG_START_POS: prdata = r_cfg.start_position;
            default:       prdata = '0;
        endcase
    end

    assign o_ready = !w_busy;
    assign w_start = i_valid && o_ready;
    assign w_hold  = r_out_valid && !i_ready;

    sjp_core #(
        .FRAC_BITS          (FRAC_BITS),
        .SMOOTH_TABLE_DEPTH (SMOOTH_TABLE_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_start   (w_start),
        .i_restart (i_restart),
        .i_hold    (w_hold),
        .o_busy    (w_busy),
        .o_commit  (w_commit),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_jerk_out     = r_out.jerk;
    assign o_accel_out    = r_out.accel;
    assign o_velocity_out = r_out.velocity;
    assign o_position_out = r_out.position;
    assign o_profile_done = r_out.done;

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_valid)
        else $error("result beat not presented after commit");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> (!r_out_valid || i_ready))
        else $error("commit over an untaken result beat");

    a_done_zero_jerk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_profile_done) |-> (o_jerk_out == 32'sd0))
        else $error("nonzero jerk after profile end");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready held across a tick in flight");

endmodule
